// ===== hw/rtl/bcu_pkg.sv =====
`default_nettype none

package bcu_pkg;

  // word width of the operands and the result
  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = WORD_W / 2;

  // divider retires this many quotient bits per cycle
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_CYCLES = WORD_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

  // main sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RANGE,
    ST_QGO,
    ST_QWAIT,
    ST_MUL,
    ST_RGO,
    ST_RWAIT,
    ST_STEP,
    ST_OUT
  } bcu_state_t;

  // partial product schedule of the shared 32x32 multiplier
  typedef enum logic [2:0] {
    MP_Q_LL,
    MP_Q_LH,
    MP_Q_HL,
    MP_R_L,
    MP_R_H,
    MP_FLUSH
  } bcu_mph_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bcu_div.sv =====
`default_nettype none

// iterative divider of a 64-bit word by a small nonzero divisor
module bcu_div #(
  parameter int unsigned DW = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [bcu_pkg::WORD_W-1:0]  dividend,
  input  wire logic [DW-1:0]               divisor,
  output logic                             done,
  output logic [bcu_pkg::WORD_W-1:0]       quot,
  output logic [DW-1:0]                    rem
);

  logic                           busy_r;
  logic                           done_r;
  logic [bcu_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [bcu_pkg::WORD_W-1:0]     num_r;
  logic [bcu_pkg::WORD_W-1:0]     num_nxt;
  logic [DW-1:0]                  rem_r;
  logic [DW-1:0]                  rem_nxt;
  logic [DW-1:0]                  den_r;

  // a few restoring steps per cycle on the narrow partial remainder
  always_comb begin
    logic [DW:0]                  t;
    logic [DW-1:0]                r;
    logic [bcu_pkg::WORD_W-1:0]   q;
    r = rem_r;
    q = num_r;
    for (int s = 0; s < bcu_pkg::DIV_BITS; s++) begin
      t = {r, q[bcu_pkg::WORD_W-1]};
      q = {q[bcu_pkg::WORD_W-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        r    = DW'(t - {1'b0, den_r});
        q[0] = 1'b1;
      end else begin
        r = t[DW-1:0];
      end
    end
    num_nxt = q;
    rem_nxt = r;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == bcu_pkg::DIV_CNT_W'(bcu_pkg::DIV_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = num_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ===== hw/rtl/binomial_coefficient_unit_top.sv =====
`default_nettype none

// channel   dir  handshake            payload
// in_       in   in_valid/in_stall    in_n_value[63:0], in_r_value[63:0]
// out_      out  out_valid/out_stall  out_comb_result[63:0]
//
// one beat in, one beat out; no new beat is taken until the result has left
// k = min(r, n-r); each step runs two divides and five 32x32 partial products
// through the shared divider and multiplier; r > n or k >= MAX_STEPS skips
// the steps and gives a zero result
// reset is synchronous and clears the sequencer; out_stall holds the result
module binomial_coefficient_unit_top #(
  parameter int unsigned MAX_STEPS = 34
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [bcu_pkg::WORD_W-1:0]  in_n_value,
  input  wire logic [bcu_pkg::WORD_W-1:0]  in_r_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [bcu_pkg::WORD_W-1:0]       out_comb_result
);

  localparam int unsigned DW = $clog2(MAX_STEPS + 1);
  localparam int unsigned WW = bcu_pkg::WORD_W;
  localparam int unsigned HW = bcu_pkg::HALF_W;

  bcu_pkg::bcu_state_t  state_r;
  bcu_pkg::bcu_state_t  state_nxt;
  bcu_pkg::bcu_mph_t    mph_r;

  logic [WW-1:0]  n_r;
  logic [WW-1:0]  r_r;
  logic [WW-1:0]  diff_r;
  logic           over_r;
  logic [DW-1:0]  k_r;
  logic [DW-1:0]  d_r;
  logic [WW-1:0]  m_r;
  logic [WW-1:0]  v_r;
  logic [WW-1:0]  accq_r;
  logic [WW-1:0]  accr_r;
  logic [WW-1:0]  prod_r;

  logic           too_big;
  logic           zero_res;
  logic [DW-1:0]  k_sel;

  logic           div_start;
  logic [WW-1:0]  div_dividend;
  logic           div_done;
  logic [WW-1:0]  div_quot;
  logic [DW-1:0]  div_rem;

  logic [HW-1:0]  mul_a;
  logic [HW-1:0]  mul_b;

  // range check: min(r, n-r) >= MAX_STEPS exactly when both are
  assign too_big  = (r_r >= WW'(MAX_STEPS)) && (diff_r >= WW'(MAX_STEPS));
  assign zero_res = over_r || too_big;
  assign k_sel    = (r_r <= diff_r) ? r_r[DW-1:0] : diff_r[DW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bcu_pkg::ST_IDLE:  if (in_valid) state_nxt = bcu_pkg::ST_SETUP;
      bcu_pkg::ST_SETUP: state_nxt = bcu_pkg::ST_RANGE;
      bcu_pkg::ST_RANGE: begin
        if (zero_res || (k_sel == '0)) state_nxt = bcu_pkg::ST_OUT;
        else                           state_nxt = bcu_pkg::ST_QGO;
      end
      bcu_pkg::ST_QGO:   state_nxt = bcu_pkg::ST_QWAIT;
      bcu_pkg::ST_QWAIT: if (div_done) state_nxt = bcu_pkg::ST_MUL;
      bcu_pkg::ST_MUL:   if (mph_r == bcu_pkg::MP_FLUSH) state_nxt = bcu_pkg::ST_RGO;
      bcu_pkg::ST_RGO:   state_nxt = bcu_pkg::ST_RWAIT;
      bcu_pkg::ST_RWAIT: if (div_done) state_nxt = bcu_pkg::ST_STEP;
      bcu_pkg::ST_STEP: begin
        if (d_r == k_r) state_nxt = bcu_pkg::ST_OUT;
        else            state_nxt = bcu_pkg::ST_QGO;
      end
      bcu_pkg::ST_OUT:   if (!out_stall) state_nxt = bcu_pkg::ST_IDLE;
      default:           state_nxt = bcu_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    div_start    = 1'b0;
    div_dividend = v_r;
    unique case (state_r)
      bcu_pkg::ST_IDLE: in_stall  = 1'b0;
      bcu_pkg::ST_QGO:  div_start = 1'b1;
      bcu_pkg::ST_RGO: begin
        div_start    = 1'b1;
        div_dividend = accr_r;
      end
      bcu_pkg::ST_OUT:  out_valid = 1'b1;
      default: begin
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // shared divider: v / d, then (rem * m) / d
  bcu_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (d_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mph_r)
      bcu_pkg::MP_Q_LL: begin
        mul_a = div_quot[HW-1:0];
        mul_b = m_r[HW-1:0];
      end
      bcu_pkg::MP_Q_LH: begin
        mul_a = div_quot[HW-1:0];
        mul_b = m_r[WW-1:HW];
      end
      bcu_pkg::MP_Q_HL: begin
        mul_a = div_quot[WW-1:HW];
        mul_b = m_r[HW-1:0];
      end
      bcu_pkg::MP_R_L: begin
        mul_a = HW'(div_rem);
        mul_b = m_r[HW-1:0];
      end
      bcu_pkg::MP_R_H: begin
        mul_a = HW'(div_rem);
        mul_b = m_r[WW-1:HW];
      end
      default: begin
      end
    endcase
  end

  // multiplier phase counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mph_r <= bcu_pkg::MP_Q_LL;
    end else if (state_r == bcu_pkg::ST_MUL) begin
      if (mph_r == bcu_pkg::MP_FLUSH) mph_r <= bcu_pkg::MP_Q_LL;
      else                            mph_r <= bcu_pkg::bcu_mph_t'(mph_r + 3'd1);
    end
  end

  // datapath: product registered, accumulated in the next cycle
  always_ff @(posedge clk) begin
    prod_r <= WW'(mul_a * mul_b);
    case (state_r)
      bcu_pkg::ST_IDLE: begin
        n_r <= in_n_value;
        r_r <= in_r_value;
      end
      bcu_pkg::ST_SETUP: begin
        diff_r <= n_r - r_r;
        over_r <= r_r > n_r;
      end
      bcu_pkg::ST_RANGE: begin
        k_r <= k_sel;
        d_r <= DW'(1);
        m_r <= n_r;
        v_r <= zero_res ? '0 : WW'(1);
      end
      bcu_pkg::ST_MUL: begin
        case (mph_r)
          bcu_pkg::MP_Q_LH: accq_r <= prod_r;
          bcu_pkg::MP_Q_HL: accq_r <= accq_r + {prod_r[HW-1:0], {HW{1'b0}}};
          bcu_pkg::MP_R_L:  accq_r <= accq_r + {prod_r[HW-1:0], {HW{1'b0}}};
          bcu_pkg::MP_R_H:  accr_r <= prod_r;
          bcu_pkg::MP_FLUSH: accr_r <= accr_r + {prod_r[HW-1:0], {HW{1'b0}}};
          default: begin
          end
        endcase
      end
      bcu_pkg::ST_STEP: begin
        v_r <= accq_r + div_quot;
        d_r <= DW'(d_r + 1'b1);
        m_r <= m_r - WW'(1);
      end
      default: begin
      end
    endcase
  end

  assign out_comb_result = v_r;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;

  localparam int unsigned WORD_W       = bcu_pkg::WORD_W;
  localparam int unsigned STEP_LIMIT   = 34;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 1500;
  localparam logic [WORD_W-1:0] ALL_ONES = '1;
  localparam logic [WORD_W-1:0] TOP_BIT  = {1'b1, {(WORD_W-1){1'b0}}};

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [WORD_W-1:0] in_n_value;
  logic [WORD_W-1:0] in_r_value;
  logic              out_valid;
  logic              out_stall;
  logic [WORD_W-1:0] out_comb_result;

  logic [WORD_W-1:0] pending_comb_q[$];
  int unsigned       error_count;
  int unsigned       cycle_count;
  int unsigned       idle_pct;
  int unsigned       stall_pct;

  binomial_coefficient_unit_top #(
    .MAX_STEPS(STEP_LIMIT)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_n_value     (in_n_value),
    .in_r_value     (in_r_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_comb_result(out_comb_result)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_top: errors");
    $finish;
  end

  // C(n,r) by the multiplicative method, every operation wrapping at 64 bits
  function automatic logic [WORD_W-1:0] calc_binomial(input logic [WORD_W-1:0] n,
                                                      input logic [WORD_W-1:0] r);
    logic [WORD_W-1:0] k;
    logic [WORD_W-1:0] v;
    logic [WORD_W-1:0] d;
    logic [WORD_W-1:0] m;
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] i;
    if (r > n) return '0;
    k = (r <= n - r) ? r : n - r;
    if (k >= STEP_LIMIT) return '0;
    v = 1;
    for (i = 0; i < k; i++) begin
      d   = i + 1;
      m   = n - i;
      rem = v % d;
      v   = (v / d) * m + (rem * m) / d;
    end
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // set size at least k for k below 2**63, spread over several magnitudes
  function automatic logic [WORD_W-1:0] pick_set_size(input logic [WORD_W-1:0] k);
    logic [WORD_W-1:0] n;
    case ($urandom_range(0, 3))
      0: n = k + $urandom_range(0, 60);
      1: n = k + $urandom;
      2: begin
        n = rand_word();
        if (n < k) n = n + k;
      end
      default: n = ALL_ONES - $urandom_range(0, 100);
    endcase
    return n;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
    $display("mismatch at cycle %0d: %s, want %h got %h", cycle_count, what, want, got);
    error_count++;
  endtask

  // one request beat, with an optional idle burst ahead of it
  task automatic send_request(input logic [WORD_W-1:0] n, input logic [WORD_W-1:0] r);
    int unsigned gap;
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 11);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_n_value = n;
    in_r_value = r;
    in_valid   = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_comb_q.push_back(calc_binomial(n, r));
  endtask

  // result stall in random bursts
  initial begin
    int unsigned burst;
    burst     = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (burst == 0 && $urandom_range(0, 99) < stall_pct) burst = $urandom_range(1, 11);
      if (burst > 0) begin
        out_stall = 1'b1;
        burst--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // result check against the oldest pending coefficient
  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_comb_q.size() == 0) begin
        report_mismatch("result with nothing pending", '0, out_comb_result);
      end else begin
        want = pending_comb_q.pop_front();
        if (out_comb_result !== want) report_mismatch("comb_result", want, out_comb_result);
      end
    end
  end

  // field extremes and each special case
  task automatic test_corners();
    idle_pct  = 30;
    stall_pct = 30;
    send_request('0, '0);
    send_request(ALL_ONES, '0);
    send_request(ALL_ONES, ALL_ONES);
    send_request('0, 64'd1);
    send_request(64'd5, ALL_ONES);
    send_request(ALL_ONES, ALL_ONES - 1);
    send_request(64'd1, 64'd1);
    send_request(64'd2, 64'd1);
    send_request(64'd10, 64'd3);
    send_request(64'd40, 64'd20);
    send_request(64'd62, 64'd31);
    send_request(64'd64, 64'd32);
    send_request(64'd66, 64'd33);
    send_request(64'd67, 64'd33);
    send_request(64'd68, 64'd33);
    send_request(64'd68, 64'd34);
    send_request(64'd100, 64'd50);
    send_request(ALL_ONES, 64'd33);
    send_request(ALL_ONES, ALL_ONES - 33);
    send_request(ALL_ONES, 64'd34);
    send_request(ALL_ONES, TOP_BIT);
    send_request(TOP_BIT, TOP_BIT >> 1);
    send_request(TOP_BIT, TOP_BIT + 1);
  endtask

  // mostly in-range requests, plus zero-result and noise requests
  task automatic test_random_mix(input int unsigned count);
    logic [WORD_W-1:0] n;
    logic [WORD_W-1:0] r;
    logic [WORD_W-1:0] k;
    int unsigned       pick;
    for (int unsigned j = 0; j < count; j++) begin
      // switch at random between calm and busy stretches
      if (j % 30 == 0) begin
        idle_pct  = $urandom_range(0, 1) ? 0 : 35;
        stall_pct = $urandom_range(0, 1) ? 0 : 35;
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        k = $urandom_range(0, STEP_LIMIT - 1);
        n = pick_set_size(k);
        r = $urandom_range(0, 1) ? k : n - k;
      end else if (pick < 75) begin
        k = $urandom_range(0, 3) == 0 ? rand_word() >> 1 : $urandom_range(STEP_LIMIT, 80);
        n = pick_set_size(k << 1);
        r = $urandom_range(0, 1) ? k : n - k;
      end else if (pick < 90) begin
        n = rand_word() >> $urandom_range(0, 63);
        r = n + 1 + $urandom_range(0, 1000);
      end else begin
        n = rand_word();
        r = rand_word();
      end
      send_request(n, r);
    end
  endtask

  // back-to-back traffic with no idling on either side
  task automatic test_back_to_back(input int unsigned count);
    logic [WORD_W-1:0] n;
    logic [WORD_W-1:0] k;
    idle_pct  = 0;
    stall_pct = 0;
    for (int unsigned j = 0; j < count; j++) begin
      k = $urandom_range(0, STEP_LIMIT - 1);
      n = pick_set_size(k);
      send_request(n, $urandom_range(0, 1) ? k : n - k);
    end
  endtask

  // reset, tests, drain and verdict
  initial begin
    error_count = 0;
    cycle_count = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_n_value  = '0;
    in_r_value  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_corners();
    test_random_mix(210);
    test_back_to_back(40);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_comb_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_comb_q.size() != 0) begin
      report_mismatch("results still pending", pending_comb_q[0], '0);
    end

    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/bcu_pkg.sv
hw/rtl/bcu_div.sv
hw/rtl/binomial_coefficient_unit_top.sv
tb/tb_top.sv
